// File: rtl/core/krsl_pkg.sv
// shared constants, command codes and control/status types for the key rollover slot logger
// no dependencies; imported by every module of the block

package krsl_pkg;

   // table geometry
   localparam int SLOTS       = 8;
   localparam int REPORT_BITS = 8;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // field widths
   localparam int CMD_W      = 3;
   localparam int CODE_W     = 8;
   localparam int SLOT_IDX_W = 4;
   localparam int MOUSE_W    = 2;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // report mask for the key value
   localparam logic [CODE_W-1:0] KEY_MASK = CODE_W'((9'd1 << REPORT_BITS) - 9'd1);

   // command codes
   localparam logic [CMD_W-1:0] CMD_KEY_DOWN   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_KEY_UP     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LEFT_DOWN  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LEFT_UP    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RIGHT_DOWN = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RIGHT_UP   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_TICK       = 3'd6;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd7;

   // register indexes
   localparam logic CSR_IDX_ENABLE = 1'b0;

   // controller to datapath commands
   typedef struct packed {
      logic apply;       // apply a non-tick word to the table
      logic tick_start;  // snapshot mouse bits and rewind the slot counter
      logic emit;        // load the next slot report into the output register
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;    // output register can take a word this cycle
      logic cnt_last;    // slot counter points at the final slot
   } ctrl_status_type;

endpackage

// File: rtl/core/krsl_ctrl.sv
// controller state machine: accepts request words and sequences the slot reports of a tick
// depends on krsl_pkg

module krsl_ctrl
   import krsl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [CMD_W-1:0] req_cmd,
   output logic            req_stall,
   input  ctrl_status_type status,
   output ctrl_cmd_type    ctrl
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_TICK = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   // request side only open while idle
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      ctrl.apply      = 1'b0;
      ctrl.tick_start = 1'b0;
      ctrl.emit       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_TICK) begin
                  ctrl.tick_start = 1'b1;
                  state_in        = ST_TICK;
               end else begin
                  ctrl.apply = 1'b1;
               end
            end
         end
         ST_TICK: begin
            if (status.out_free) begin
               ctrl.emit = 1'b1;
               if (status.cnt_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/krsl_datapath.sv
// datapath: key slot table, mouse latches, slot counter and the report output register
// depends on krsl_pkg

module krsl_datapath
   import krsl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  logging_enable,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [CODE_W-1:0]     req_key_code,
   input  ctrl_cmd_type          ctrl,
   output ctrl_status_type       status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SLOT_IDX_W-1:0] rsp_slot_index,
   output logic [CODE_W-1:0]     rsp_key_value,
   output logic [MOUSE_W-1:0]    rsp_mouse_keys,
   output logic                  rsp_last
);

   logic [CODE_W-1:0]     slot_code_ff [SLOTS];
   logic [CODE_W-1:0]     slot_code_in [SLOTS];
   logic [SLOTS-1:0]      slot_rel_ff;
   logic [SLOTS-1:0]      slot_rel_in;
   logic                  left_pressed_ff, left_pressed_in;
   logic                  left_rel_ff, left_rel_in;
   logic                  right_pressed_ff, right_pressed_in;
   logic                  right_rel_ff, right_rel_in;
   logic [MOUSE_W-1:0]    mouse_ff, mouse_in;
   logic [SLOT_W-1:0]     cnt_ff, cnt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_IDX_W-1:0] rsp_slot_index_ff, rsp_slot_index_in;
   logic [CODE_W-1:0]     rsp_key_value_ff, rsp_key_value_in;
   logic [MOUSE_W-1:0]    rsp_mouse_keys_ff, rsp_mouse_keys_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  held;
   logic                  empty_found;
   logic [SLOT_W-1:0]     empty_idx;
   logic                  up_found;
   logic [SLOT_W-1:0]     up_idx;
   logic                  code_nz;

   assign code_nz = (req_key_code != '0);

   // slot searches: held unreleased, first empty, first holding the code
   always_comb begin
      held        = 1'b0;
      empty_found = 1'b0;
      empty_idx   = '0;
      up_found    = 1'b0;
      up_idx      = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_code_ff[i] == req_key_code && !slot_rel_ff[i]) begin
            held = 1'b1;
         end
         if (!empty_found && slot_code_ff[i] == '0) begin
            empty_found = 1'b1;
            empty_idx   = SLOT_W'(i);
         end
         if (!up_found && slot_code_ff[i] == req_key_code) begin
            up_found = 1'b1;
            up_idx   = SLOT_W'(i);
         end
      end
   end

   // table and latch updates
   always_comb begin
      slot_code_in     = slot_code_ff;
      slot_rel_in      = slot_rel_ff;
      left_pressed_in  = left_pressed_ff;
      left_rel_in      = left_rel_ff;
      right_pressed_in = right_pressed_ff;
      right_rel_in     = right_rel_ff;
      mouse_in         = mouse_ff;
      cnt_in           = cnt_ff;

      if (ctrl.apply) begin
         if (req_cmd == CMD_CLEAR) begin
            for (int i = 0; i < SLOTS; i++) begin
               slot_code_in[i] = '0;
            end
            slot_rel_in      = '0;
            left_pressed_in  = 1'b0;
            left_rel_in      = 1'b0;
            right_pressed_in = 1'b0;
            right_rel_in     = 1'b0;
         end else if (logging_enable) begin
            unique case (req_cmd)
               CMD_KEY_DOWN: begin
                  if (code_nz && !held && empty_found) begin
                     slot_code_in[empty_idx] = req_key_code;
                     slot_rel_in[empty_idx]  = 1'b0;
                  end
               end
               CMD_KEY_UP: begin
                  if (code_nz && up_found) begin
                     slot_rel_in[up_idx] = 1'b1;
                  end
               end
               CMD_LEFT_DOWN: begin
                  left_pressed_in = 1'b1;
                  left_rel_in     = 1'b0;
               end
               CMD_LEFT_UP:    left_rel_in = 1'b1;
               CMD_RIGHT_DOWN: begin
                  right_pressed_in = 1'b1;
                  right_rel_in     = 1'b0;
               end
               CMD_RIGHT_UP:   right_rel_in = 1'b1;
               default: ;
            endcase
         end
      end

      // tick start: snapshot the buttons, drop released presses
      if (ctrl.tick_start) begin
         mouse_in = {right_pressed_ff, left_pressed_ff};
         cnt_in   = '0;
         if (left_rel_ff) begin
            left_pressed_in = 1'b0;
         end
         if (right_rel_ff) begin
            right_pressed_in = 1'b0;
         end
      end

      // report step: empty the slot once it has been reported as released
      if (ctrl.emit) begin
         cnt_in = cnt_ff + SLOT_W'(1);
         if (slot_rel_ff[cnt_ff]) begin
            slot_code_in[cnt_ff] = '0;
            slot_rel_in[cnt_ff]  = 1'b0;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_slot_index_in = rsp_slot_index_ff;
      rsp_key_value_in  = rsp_key_value_ff;
      rsp_mouse_keys_in = rsp_mouse_keys_ff;
      rsp_last_in       = rsp_last_ff;
      if (ctrl.emit) begin
         rsp_valid_in      = 1'b1;
         rsp_slot_index_in = SLOT_IDX_W'(cnt_ff);
         rsp_key_value_in  = slot_code_ff[cnt_ff] & KEY_MASK;
         rsp_mouse_keys_in = mouse_ff;
         rsp_last_in       = status.cnt_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.cnt_last = (cnt_ff == SLOT_W'(SLOTS - 1));

   // state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_code_ff[i] <= '0;
         end
         slot_rel_ff      <= '0;
         left_pressed_ff  <= 1'b0;
         left_rel_ff      <= 1'b0;
         right_pressed_ff <= 1'b0;
         right_rel_ff     <= 1'b0;
         cnt_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         slot_code_ff     <= slot_code_in;
         slot_rel_ff      <= slot_rel_in;
         left_pressed_ff  <= left_pressed_in;
         left_rel_ff      <= left_rel_in;
         right_pressed_ff <= right_pressed_in;
         right_rel_ff     <= right_rel_in;
         cnt_ff           <= cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mouse_ff          <= mouse_in;
      rsp_slot_index_ff <= rsp_slot_index_in;
      rsp_key_value_ff  <= rsp_key_value_in;
      rsp_mouse_keys_ff <= rsp_mouse_keys_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = rsp_slot_index_ff;
   assign rsp_key_value  = rsp_key_value_ff;
   assign rsp_mouse_keys = rsp_mouse_keys_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// File: rtl/core/key_rollover_slot_logger_core.sv
// Top level of the key rollover slot logger: enable register, controller and datapath.
// Non-tick words are applied while idle; the next word is accepted in the following cycle.
// A tick moves one slot report per cycle from the
// slot counter into the output register, and pauses while the result side stalls.
// Reset (synchronous, active high) empties every slot, clears the button latches
// and leaves logging disabled. Depends on krsl_pkg, krsl_ctrl and krsl_datapath.

module key_rollover_slot_logger_core
   import krsl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [CODE_W-1:0]     req_key_code,
   // report channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SLOT_IDX_W-1:0] rsp_slot_index,
   output logic [CODE_W-1:0]     rsp_key_value,
   output logic [MOUSE_W-1:0]    rsp_mouse_keys,
   output logic                  rsp_last,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   ctrl_cmd_type    ctrl;
   ctrl_status_type status;
   logic            enable_ff;
   logic            enable_in;
   logic            csr_idx;
   logic            csr_wr;

   // register decode: word index from the byte address
   assign pready  = 1'b1;
   assign csr_idx = paddr[2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      enable_in = enable_ff;
      if (csr_wr && csr_idx == CSR_IDX_ENABLE) begin
         enable_in = pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_idx == CSR_IDX_ENABLE) begin
         prdata = CSR_DATA_W'(enable_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   // controller
   krsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   // datapath
   krsl_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .logging_enable (enable_ff),
      .req_cmd        (req_cmd),
      .req_key_code   (req_key_code),
      .ctrl           (ctrl),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot_index (rsp_slot_index),
      .rsp_key_value  (rsp_key_value),
      .rsp_mouse_keys (rsp_mouse_keys),
      .rsp_last       (rsp_last)
   );

endmodule
